// File: rtl/accel_kalman_velocity_integrator_core_assert.svh
// Assertion macros for the Kalman velocity integrator core.
// Included by the top level; no other dependencies.
`ifndef ACCEL_KALMAN_VELOCITY_INTEGRATOR_CORE_ASSERT_SVH
`define ACCEL_KALMAN_VELOCITY_INTEGRATOR_CORE_ASSERT_SVH

// clocked assertion, ignored during reset
`define KVI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication form
`define KVI_ASSERT_IMP(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

// File: rtl/kvi_pkg.sv
// Shared types and constants for the Kalman velocity integrator.
// No dependencies.
`timescale 1ns / 1ps

package kvi_pkg;
   localparam int AXIS_COUNT = 3;
   localparam int CSR_IDX_W  = 8;

   localparam logic [CSR_IDX_W-1:0] CFG_Q     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_R     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_P0    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_OFF_X = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_OFF_Y = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_OFF_Z = 8'd5;

   localparam logic [15:0] Q_RST  = 16'd256;
   localparam logic [15:0] R_RST  = 16'd1280;
   localparam logic [15:0] P0_RST = 16'd26;
   localparam logic signed [15:0] OFF_Z_RST = 16'sd2048;
   localparam logic signed [31:0] EST_Z_RST = 32'sh0800_0000;

   localparam logic signed [47:0] VEL_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] VEL_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic start;
      logic load_p;
   } kvi_ctrl_type;
endpackage

// File: rtl/accel_kalman_velocity_integrator_core.sv
// Top level of the accelerometer Kalman filter and velocity integrator.
// Depends on kvi_pkg, kvi_lane, kvi_div and the assertion macro header.
//
// Usage:
//  - req_* channel: one frame (raw_x/y/z, elapsed_ms) per transfer, taken when
//    req_valid is high and req_stall is low.
//  - rsp_* channel: one result per frame (filtered and speed per axis), handed
//    over when rsp_valid is high and rsp_stall is low.
//  - csr_* channel: register writes (index, data), always ready; write only
//    while no frame is in flight.
//  - Response time is set by the 17-step iterative gain divider each axis lane
//    carries plus pre/post steps.
//  - Frames do not overlap: req_stall is high while a frame is in the lanes;
//    all three axis lanes run side by side, and a new frame is taken while a
//    previous result still waits in the output register.
//  - When the receiver stalls, a finished frame waits in the lanes and
//    req_stall stays high until the output register is free.
//  - Reset (synchronous): registers return to Q=256, R=1280, P0=26, offsets
//    0/0/2048, filter state to its start values, no result pending.
`timescale 1ns / 1ps

`include "accel_kalman_velocity_integrator_core_assert.svh"

module accel_kalman_velocity_integrator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [15:0]                req_raw_x,
   input  logic signed [15:0]                req_raw_y,
   input  logic signed [15:0]                req_raw_z,
   input  logic [15:0]                       req_elapsed_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_filtered_x,
   output logic signed [15:0]                rsp_filtered_y,
   output logic signed [15:0]                rsp_filtered_z,
   output logic signed [47:0]                rsp_speed_x,
   output logic signed [47:0]                rsp_speed_y,
   output logic signed [47:0]                rsp_speed_z,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kvi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                       csr_wdata
);
   import kvi_pkg::*;

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_RUN  = 2'd1;
   localparam logic [1:0] T_HOLD = 2'd2;

   logic [1:0]  st_ff, st_in;
   logic [15:0] q_ff, r_ff;
   logic signed [15:0] off_ff [AXIS_COUNT];
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] filt_out_ff [AXIS_COUNT];
   logic signed [47:0] spd_out_ff  [AXIS_COUNT];

   kvi_ctrl_type       ctrl;
   logic               req_xfer, csr_xfer, out_free, load_out;
   logic [AXIS_COUNT-1:0] lane_done;
   logic signed [15:0] samples   [AXIS_COUNT];
   logic signed [31:0] est_init  [AXIS_COUNT];
   logic signed [15:0] lane_filt [AXIS_COUNT];
   logic signed [47:0] lane_spd  [AXIS_COUNT];

   assign samples[0] = req_raw_x;
   assign samples[1] = req_raw_y;
   assign samples[2] = req_raw_z;
   assign est_init[0] = '0;
   assign est_init[1] = '0;
   assign est_init[2] = EST_Z_RST;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign req_stall = (st_ff != T_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ctrl.start  = req_xfer;
   assign ctrl.load_p = csr_xfer && (csr_index == CFG_P0);

   for (genvar i = 0; i < AXIS_COUNT; i++) begin : g_lane
      kvi_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .sample  (samples[i]),
         .dt      (req_elapsed_ms),
         .q       (q_ff),
         .r       (r_ff),
         .p0      (csr_wdata),
         .offset  (off_ff[i]),
         .est_rst (est_init[i]),
         .done    (lane_done[i]),
         .filt    (lane_filt[i]),
         .speed   (lane_spd[i])
      );
   end

   always_comb begin
      st_in        = st_ff;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (st_ff)
         T_IDLE: if (req_xfer) st_in = T_RUN;
         T_RUN: begin
            if (lane_done[0]) begin
               if (out_free) begin
                  load_out = 1'b1;
                  st_in    = T_IDLE;
               end else begin
                  st_in = T_HOLD;
               end
            end
         end
         T_HOLD: begin
            if (out_free) begin
               load_out = 1'b1;
               st_in    = T_IDLE;
            end
         end
         default: st_in = T_IDLE;
      endcase
      if (load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int i = 0; i < AXIS_COUNT; i++) begin
            filt_out_ff[i] <= lane_filt[i];
            spd_out_ff[i]  <= lane_spd[i];
         end
      end
      if (reset) begin
         st_ff        <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         q_ff         <= Q_RST;
         r_ff         <= R_RST;
         off_ff[0]    <= '0;
         off_ff[1]    <= '0;
         off_ff[2]    <= OFF_Z_RST;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_xfer) begin
            unique case (csr_index)
               CFG_Q:     q_ff      <= csr_wdata;
               CFG_R:     r_ff      <= csr_wdata;
               CFG_OFF_X: off_ff[0] <= csr_wdata;
               CFG_OFF_Y: off_ff[1] <= csr_wdata;
               CFG_OFF_Z: off_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filtered_x = filt_out_ff[0];
   assign rsp_filtered_y = filt_out_ff[1];
   assign rsp_filtered_z = filt_out_ff[2];
   assign rsp_speed_x    = spd_out_ff[0];
   assign rsp_speed_y    = spd_out_ff[1];
   assign rsp_speed_z    = spd_out_ff[2];

   `KVI_ASSERT(a_lanes_lockstep, (lane_done == '0) || (lane_done == '1), "lanes out of step")
   `KVI_ASSERT_IMP(a_start_runs, req_xfer, ##1 (st_ff == T_RUN), "transfer did not start lanes")
   `KVI_ASSERT_IMP(a_hold_full, st_ff == T_HOLD, rsp_valid_ff, "hold without pending result")
   `KVI_ASSERT_IMP(a_done_in_run, lane_done[0], st_ff == T_RUN, "lane done outside run")
endmodule

// File: rtl/kvi_div.sv
// Restoring divider: 17 quotient bits of (p << 16) / den, one bit per cycle.
// Uses no package items.
`timescale 1ns / 1ps

module kvi_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] p,
   input  logic [32:0] den,
   output logic        done,
   output logic [16:0] quo
);
   logic [33:0] rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [16:0] nb_ff, nb_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      nb_in   = nb_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[32:0], nb_ff[16]};
      if (start) begin
         rem_in = {3'b000, p[31:1]};
         nb_in  = {p[0], 16'h0000};
         cnt_in = 5'd0;
         run_in = 1'b1;
         quo_in = '0;
      end else if (run_ff) begin
         nb_in = {nb_ff[15:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            rem_in = trial - {1'b0, den};
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      nb_ff  <= nb_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

// File: rtl/kvi_lane.sv
// One axis: scalar Kalman step and saturating trapezoid velocity sum.
// Depends on kvi_pkg and kvi_div.
`timescale 1ns / 1ps

module kvi_lane (
   input  logic                 clock,
   input  logic                 reset,
   input  kvi_pkg::kvi_ctrl_type ctrl,
   input  logic signed [15:0]   sample,
   input  logic [15:0]          dt,
   input  logic [15:0]          q,
   input  logic [15:0]          r,
   input  logic [15:0]          p0,
   input  logic signed [15:0]   offset,
   input  logic signed [31:0]   est_rst,
   output logic                 done,
   output logic signed [15:0]   filt,
   output logic signed [47:0]   speed
);
   import kvi_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PRED = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_UPD  = 3'd3;
   localparam logic [2:0] S_FILT = 3'd4;
   localparam logic [2:0] S_MUL  = 3'd5;
   localparam logic [2:0] S_SAT  = 3'd6;

   logic [2:0]  st_ff, st_in;
   logic signed [31:0] est_ff, est_in;
   logic [31:0] cov_ff, cov_in;
   logic signed [15:0] prev_ff, prev_in;
   logic signed [47:0] vel_ff, vel_in;
   logic signed [15:0] smp_ff;
   logic [15:0] dt_ff;
   logic [31:0] p_ff;
   logic [32:0] den_ff;
   logic [15:0] g_ff;
   logic signed [49:0] pe_ff;
   logic [48:0] pp_ff;
   logic signed [15:0] filt_ff;
   logic signed [17:0] sum_ff;
   logic signed [34:0] term_ff;
   logic        done_ff;

   logic        div_start, div_done;
   logic [16:0] div_quo;
   logic [32:0] psum;
   logic signed [32:0] diff;
   logic signed [31:0] est_new;
   logic signed [15:0] filt_new;
   logic signed [48:0] vsum;

   function automatic logic signed [16:0] sample_ext(input logic signed [15:0] s);
      sample_ext = {s[15], s};
   endfunction

   kvi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .p     (p_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign psum      = {1'b0, cov_ff} + {9'd0, q, 8'd0};
   assign div_start = (st_ff == S_PRED);
   assign diff      = {sample_ext(smp_ff), 16'h0000} - {est_ff[31], est_ff};
   assign est_new   = est_ff + pe_ff[47:16];
   assign filt_new  = est_new[31:16] +
                      16'((est_new[31] && (est_new[15:0] != 16'h0000)) ? 1 : 0);
   assign vsum      = {vel_ff[47], vel_ff} + 49'(term_ff);

   always_comb begin
      st_in   = st_ff;
      est_in  = est_ff;
      cov_in  = cov_ff;
      prev_in = prev_ff;
      vel_in  = vel_ff;
      unique case (st_ff)
         S_IDLE: if (ctrl.start) st_in = S_PRED;
         S_PRED: st_in = S_DIV;
         S_DIV:  if (div_done) st_in = S_UPD;
         S_UPD:  st_in = S_FILT;
         S_FILT: begin
            est_in = est_new;
            cov_in = pp_ff[47:16];
            st_in  = S_MUL;
         end
         S_MUL:  st_in = S_SAT;
         S_SAT: begin
            if (vsum[48] != vsum[47]) begin
               vel_in = vsum[48] ? VEL_MIN : VEL_MAX;
            end else begin
               vel_in = vsum[47:0];
            end
            prev_in = filt_ff;
            st_in   = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (ctrl.load_p) cov_in = {8'd0, p0, 8'd0};
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && ctrl.start) begin
         smp_ff <= sample;
         dt_ff  <= dt;
         p_ff   <= psum[32] ? 32'hFFFF_FFFF : psum[31:0];
      end
      if (st_ff == S_PRED) den_ff <= {1'b0, p_ff} + {9'd0, r, 8'd0};
      if (div_done) begin
         if (den_ff == 33'd0)  g_ff <= 16'd0;
         else if (div_quo[16]) g_ff <= 16'hFFFF;
         else                  g_ff <= div_quo[15:0];
      end
      if (st_ff == S_UPD) begin
         pe_ff <= $signed({1'b0, g_ff}) * diff;
         pp_ff <= (17'h10000 - {1'b0, g_ff}) * p_ff;
      end
      if (st_ff == S_FILT) begin
         filt_ff <= filt_new;
         sum_ff  <= 18'(filt_new) + 18'(prev_ff) - (18'(offset) <<< 1);
      end
      if (st_ff == S_MUL) term_ff <= sum_ff * $signed({1'b0, dt_ff});
      if (reset) begin
         st_ff   <= S_IDLE;
         est_ff  <= est_rst;
         cov_ff  <= {8'd0, P0_RST, 8'd0};
         prev_ff <= '0;
         vel_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         est_ff  <= est_in;
         cov_ff  <= cov_in;
         prev_ff <= prev_in;
         vel_ff  <= vel_in;
         done_ff <= (st_ff == S_SAT);
      end
   end

   assign done  = done_ff;
   assign filt  = prev_ff;
   assign speed = vel_ff;
endmodule
